@@ rtl/lc4_pkg.sv @@
package lc4_pkg;

    typedef struct packed {
        logic        action;
        logic [15:0] load_address;
        logic [15:0] load_word;
    } lc4_in_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] instruction;
        logic        reg_write;
        logic [2:0]  dest_index;
        logic [15:0] reg_value;
        logic        nzp_write;
        logic [2:0]  nzp_value;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
        logic [2:0]  status;
    } lc4_out_t;

    localparam logic [15:0] PC_RESET = 16'h8200;
    localparam int unsigned MEM_DEPTH = 65536;
    localparam int unsigned MEM_AW = 16;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FETCH_DATA = 3'd1;
    localparam logic [2:0] ST_PRIV = 3'd2;
    localparam logic [2:0] ST_LOAD_CODE = 3'd3;
    localparam logic [2:0] ST_STORE_CODE = 3'd4;

    localparam logic [3:0] OP_BR = 4'h0;
    localparam logic [3:0] OP_ARITH = 4'h1;
    localparam logic [3:0] OP_CMP = 4'h2;
    localparam logic [3:0] OP_JSR = 4'h4;
    localparam logic [3:0] OP_LOGIC = 4'h5;
    localparam logic [3:0] OP_LDR = 4'h6;
    localparam logic [3:0] OP_STR = 4'h7;
    localparam logic [3:0] OP_RTI = 4'h8;
    localparam logic [3:0] OP_CONST = 4'h9;
    localparam logic [3:0] OP_SHIFT = 4'hA;
    localparam logic [3:0] OP_JMP = 4'hC;
    localparam logic [3:0] OP_HICONST = 4'hD;
    localparam logic [3:0] OP_TRAP = 4'hF;

    // controller -> datapath commands
    typedef struct packed {
        logic clear_step;   // write zero at clear address
        logic load_write;   // write load item into memory
        logic fetch_rd;     // issue memory read at pc
        logic latch_insn;   // capture instruction
        logic div_start;
        logic exec;         // compute results, issue data read
        logic commit;       // update state, build record
    } lc4_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic need_div;
        logic div_busy;
        logic undefined;
    } lc4_sts_t;

    function automatic logic [2:0] nzp_of(input logic [15:0] v);
        if (v == 16'd0) return 3'd2;
        return v[15] ? 3'd4 : 3'd1;
    endfunction

    function automatic logic [2:0] cmp_code(input logic [15:0] a, input logic [15:0] b);
        if (a == b) return 3'd2;
        return (a < b) ? 3'd4 : 3'd1;
    endfunction

endpackage

@@ rtl/lc4_ram.sv @@
module lc4_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/lc4_div.sv @@
module lc4_div import lc4_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);
    // restoring divide, one quotient bit per cycle
    logic [15:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic [16:0] trial;

    always_comb begin
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        trial    = {r_reg[15:0], q_reg[15]} - {1'b0, d_reg};
        if (start) begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = 5'd16;
        end else if (cnt_reg != 5'd0) begin
            if (!trial[16]) begin
                r_next = trial;
                q_next = {q_reg[14:0], 1'b1};
            end else begin
                r_next = {r_reg[15:0], q_reg[15]};
                q_next = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= divisor;
        end
    end

    assign busy      = (cnt_reg != 5'd0);
    assign quotient  = (d_reg == 16'd0) ? 16'd0 : q_reg;
    assign remainder = (d_reg == 16'd0) ? 16'd0 : r_reg[15:0];
endmodule

@@ rtl/lc4_datapath.sv @@
module lc4_datapath import lc4_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lc4_cmd_t    cmd,
    output lc4_sts_t    sts,
    input  lc4_in_t     in_item,
    output lc4_out_t    rec
);
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg;
    logic        priv_reg;
    logic [2:0]  cc_reg;
    logic [15:0] insn_reg;
    logic [16:0] clr_reg;     // clear sweep address, top bit marks done

    logic              we;
    logic [MEM_AW-1:0] waddr, raddr;
    logic [15:0]       wdata, rdata;

    logic [15:0] quo, rem;
    logic        dbusy;

    // registered execute results
    logic [15:0] val_reg, addr_reg, next_reg, stv_reg;
    logic        rw_reg, nw_reg;
    logic [2:0]  nz_reg, dr_reg, st_reg;
    logic        isld_reg, isst_reg, isdiv_reg, ismod_reg, setp_reg, clrp_reg;

    logic [3:0]  op;
    logic [2:0]  d, s, t;
    logic [15:0] rs, rt, rd, next1, ea;
    logic [15:0] sx5, sx6, sx7, sx9, sx11;
    logic        pc_data;

    assign op    = insn_reg[15:12];
    assign d     = insn_reg[11:9];
    assign s     = insn_reg[8:6];
    assign t     = insn_reg[2:0];
    assign rs    = rf_reg[s];
    assign rt    = rf_reg[t];
    assign rd    = rf_reg[d];
    assign next1 = pc_reg + 16'd1;
    assign sx5   = {{11{insn_reg[4]}}, insn_reg[4:0]};
    assign sx6   = {{10{insn_reg[5]}}, insn_reg[5:0]};
    assign sx7   = {{9{insn_reg[6]}}, insn_reg[6:0]};
    assign sx9   = {{7{insn_reg[8]}}, insn_reg[8:0]};
    assign sx11  = {{5{insn_reg[10]}}, insn_reg[10:0]};
    assign ea    = rs + sx6;
    assign pc_data = (pc_reg >= 16'h2000 && pc_reg <= 16'h7FFF) || pc_reg >= 16'hA000;

    always_comb begin
        we    = 1'b0;
        waddr = in_item.load_address;
        wdata = in_item.load_word;
        if (cmd.clear_step) begin
            we    = 1'b1;
            waddr = clr_reg[15:0];
            wdata = '0;
        end else if (cmd.load_write) begin
            we = 1'b1;
        end else if (cmd.commit && isst_reg && st_reg == ST_OK) begin
            we    = 1'b1;
            waddr = addr_reg;
            wdata = stv_reg;
        end
    end

    // data address held after execute so the loaded word is still there at commit
    assign raddr = cmd.fetch_rd ? pc_reg : (cmd.exec ? ea : addr_reg);

    lc4_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    lc4_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (rs),
        .divisor   (rt),
        .busy      (dbusy),
        .quotient  (quo),
        .remainder (rem)
    );

    assign sts.clear_done = clr_reg[16];
    assign sts.div_busy   = dbusy;
    assign sts.need_div   = (op == OP_ARITH && !insn_reg[5] && insn_reg[4:3] == 2'd3)
                         || (op == OP_SHIFT && insn_reg[5:4] == 2'd3);
    assign sts.undefined  = !pc_data && (op == 4'h3 || op == 4'hB || op == 4'hE);

    // execute-phase decode
    logic [15:0] e_val, e_next, sra_v;
    logic        e_rw, e_nw, e_ld, e_st, e_div, e_mod, e_setp, e_clrp;
    logic [2:0]  e_nz, e_dr, e_st_code;

    always_comb begin
        e_val = '0; e_next = next1; e_rw = 1'b0; e_nw = 1'b0; e_nz = '0; e_dr = d;
        e_ld = 1'b0; e_st = 1'b0; e_div = 1'b0; e_mod = 1'b0; e_setp = 1'b0;
        e_clrp = 1'b0; e_st_code = ST_OK;
        sra_v = 16'($signed(rs) >>> insn_reg[3:0]);
        if (pc_data) begin
            e_st_code = ST_FETCH_DATA;
        end else begin
            unique case (op)
                OP_BR: begin
                    if ((d & cc_reg) != 3'd0) e_next = next1 + sx9;
                end
                OP_ARITH: begin
                    e_rw = 1'b1;
                    if (insn_reg[5]) e_val = rs + sx5;
                    else begin
                        unique case (insn_reg[4:3])
                            2'd0: e_val = rs + rt;
                            2'd1: e_val = 16'(rs * rt);
                            2'd2: e_val = rs - rt;
                            default: e_div = 1'b1;
                        endcase
                    end
                end
                OP_CMP: begin
                    e_nw = 1'b1;
                    unique case (insn_reg[8:7])
                        2'd0: e_nz = cmp_code(rd ^ 16'h8000, rt ^ 16'h8000);
                        2'd1: e_nz = cmp_code(rd, rt);
                        2'd2: e_nz = cmp_code(rd ^ 16'h8000, sx7 ^ 16'h8000);
                        default: e_nz = cmp_code(rd, {9'd0, insn_reg[6:0]});
                    endcase
                end
                OP_JSR: begin
                    e_val = next1; e_rw = 1'b1; e_dr = 3'd7;
                    // offset scaled by 16, sign bit ORed with pc bit 15 into bit 15
                    if (insn_reg[11]) e_next = {pc_reg[15] | sx11[11], sx11[10:0], 4'd0};
                    else e_next = rs;
                end
                OP_LOGIC: begin
                    e_rw = 1'b1;
                    if (insn_reg[5]) e_val = rs & sx5;
                    else begin
                        unique case (insn_reg[5:3])
                            3'd0: e_val = rs & rt;
                            3'd1: e_val = ~rs;
                            3'd2: e_val = rs | rt;
                            default: e_val = rs ^ rt;
                        endcase
                    end
                end
                OP_LDR, OP_STR: begin
                    if (ea >= 16'h8000 && !priv_reg) e_st_code = ST_PRIV;
                    else if (ea <= 16'h1FFF || (ea >= 16'h8000 && ea <= 16'h9FFF))
                        e_st_code = (op == OP_LDR) ? ST_LOAD_CODE : ST_STORE_CODE;
                    else if (op == OP_LDR) begin
                        e_ld = 1'b1; e_rw = 1'b1;
                    end else e_st = 1'b1;
                end
                OP_RTI: begin
                    e_next = rf_reg[7]; e_clrp = 1'b1;
                end
                OP_CONST: begin
                    e_val = sx9; e_rw = 1'b1;
                end
                OP_SHIFT: begin
                    e_rw = 1'b1;
                    unique case (insn_reg[5:4])
                        2'd0: e_val = rs << insn_reg[3:0];
                        2'd1: e_val = sra_v;
                        2'd2: e_val = rs >> insn_reg[3:0];
                        default: e_mod = 1'b1;
                    endcase
                end
                OP_JMP: begin
                    if (insn_reg[11]) e_next = next1 + sx11;
                    else e_next = rs;
                end
                OP_HICONST: begin
                    e_val = {insn_reg[7:0], rd[7:0]}; e_rw = 1'b1;
                end
                OP_TRAP: begin
                    e_val = next1; e_next = {8'h80, insn_reg[7:0]};
                    e_setp = 1'b1; e_rw = 1'b1; e_dr = 3'd7;
                end
                default: ;
            endcase
        end
        if (e_st_code != ST_OK) begin
            e_next = next1; e_rw = 1'b0; e_nw = 1'b0; e_ld = 1'b0; e_st = 1'b0;
            e_div = 1'b0; e_mod = 1'b0; e_setp = 1'b0; e_clrp = 1'b0; e_dr = '0;
        end
    end

    // commit-phase final values
    logic [15:0] c_val;
    always_comb begin
        priority if (isld_reg) c_val = rdata;
        else if (isdiv_reg) c_val = quo;
        else if (ismod_reg) c_val = rem;
        else c_val = val_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) rf_reg[i] <= '0;
            pc_reg   <= PC_RESET;
            priv_reg <= 1'b1;
            cc_reg   <= 3'd2;
            clr_reg  <= '0;
        end else begin
            if (cmd.clear_step) clr_reg <= clr_reg + 17'd1;
            if (cmd.commit) begin
                pc_reg <= next_reg;
                if (setp_reg) priv_reg <= 1'b1;
                if (clrp_reg) priv_reg <= 1'b0;
                if (rw_reg) begin
                    rf_reg[dr_reg] <= c_val;
                    cc_reg <= nzp_of(c_val);
                end else if (nw_reg) begin
                    cc_reg <= nz_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_insn) insn_reg <= rdata;
        if (cmd.exec) begin
            val_reg <= e_val; next_reg <= e_next; rw_reg <= e_rw; nw_reg <= e_nw;
            nz_reg <= e_nz; dr_reg <= e_dr; st_reg <= e_st_code; addr_reg <= ea;
            stv_reg <= rd; isld_reg <= e_ld; isst_reg <= e_st; isdiv_reg <= e_div;
            ismod_reg <= e_mod; setp_reg <= e_setp; clrp_reg <= e_clrp;
        end
        if (cmd.commit) begin
            rec.pc          <= pc_reg;
            rec.instruction <= insn_reg;
            rec.reg_write   <= rw_reg;
            rec.dest_index  <= rw_reg ? dr_reg : 3'd0;
            rec.reg_value   <= rw_reg ? c_val : 16'd0;
            rec.nzp_write   <= rw_reg | nw_reg;
            rec.nzp_value   <= rw_reg ? nzp_of(c_val) : (nw_reg ? nz_reg : 3'd0);
            rec.mem_write   <= isst_reg;
            rec.mem_address <= (isld_reg | isst_reg) ? addr_reg : 16'd0;
            rec.mem_value   <= isld_reg ? rdata : (isst_reg ? stv_reg : 16'd0);
            rec.status      <= st_reg;
        end
    end
endmodule

@@ rtl/lc4_ctrl.sv @@
module lc4_ctrl import lc4_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_action,
    output logic     m_valid,
    input  logic     m_ready,
    input  lc4_sts_t sts,
    output lc4_cmd_t cmd
);
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_DECODE = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_MEM    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       acc;

    // record register is free when empty or being taken this cycle
    assign s_ready = (state_reg == S_IDLE) && (!mv_reg || m_ready);
    assign acc     = s_valid && s_ready;
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = !sts.clear_done;
                if (sts.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    if (s_action) begin
                        cmd.fetch_rd = 1'b1;
                        state_next   = S_FETCH;
                    end else cmd.load_write = 1'b1;
                end
            end
            S_FETCH: begin
                cmd.latch_insn = 1'b1;
                state_next     = S_DECODE;
            end
            S_DECODE: begin
                if (sts.undefined) state_next = S_IDLE;
                else begin
                    cmd.exec = 1'b1;
                    cmd.div_start = sts.need_div;
                    state_next = sts.need_div ? S_DIV : S_EXEC;
                end
            end
            S_DIV: begin
                if (!sts.div_busy) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_MEM;
            end
            S_MEM: begin
                cmd.commit = 1'b1;
                mv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule

@@ rtl/lc4_instruction_step.sv @@
// channel | direction | signals                 | payload
// s_      | in        | s_valid / s_ready       | s_data  (lc4_in_t)
// m_      | out       | m_valid / m_ready       | m_data  (lc4_out_t)
//
// a load beat writes memory when taken; a step runs fetch read, latch, decode and
// execute with data read, wait, commit; div and mod also wait on the 16-step
// divider before the wait; an undefined opcode ends after decode with no record
// reset sweeps all 65536 memory words to zero, one per cycle; no beat is
// taken during the sweep
// the record register holds one result; the next beat is taken in the
// cycle the pending result drains
module lc4_instruction_step import lc4_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lc4_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lc4_out_t m_data
);
    lc4_cmd_t cmd;
    lc4_sts_t sts;

    // sequencer: clear sweep, then a load write or fetch/decode/execute/commit per step
    lc4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_data.action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // architectural state, memory, alu, divider and record register
    lc4_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .in_item (s_data),
        .rec     (m_data)
    );
endmodule

@@ rtl/lc4_checker.sv @@
module lc4_checker import lc4_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input lc4_out_t m_data
);
    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // never a valid result straight out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a fault record carries no writes
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            !m_data.reg_write && !m_data.mem_write && !m_data.nzp_write)
        else $error("fault record with writes");

    // steps are not overlapped: s_ready is low while the step that raises m_valid commits
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("beat taken while step in flight");
endmodule

bind lc4_instruction_step lc4_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
